[design/tbm_pkg.sv]
`default_nettype none
package tbm_pkg;

  localparam int ADDR_BITS_DEF  = 16;
  localparam int INST_KINDS_DEF = 32;
  localparam int MAX_CELL_DEF   = 65536;

  // result field widths
  localparam int CNT_W   = 17;
  localparam int BYTE_W  = 8;
  localparam int INST_W  = 5;
  localparam int ORDER_W = 5;

  // flag bit positions inside a stored byte
  localparam int FLAG_LSB = 5;
  localparam int NUM_FLAGS = 3;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_SET       = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_RENDER    = 3'd4;
  localparam logic [2:0] OP_HIST      = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WB,
    ST_H_DEC,
    ST_H_RD,
    ST_H_INC,
    ST_HQ_RD,
    ST_HQ_OUT,
    ST_REN_MUL,
    ST_REN_LOOP,
    ST_REN_TAIL,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

endpackage
`default_nettype wire

[design/tbm_div.sv]
`default_nettype none
module tbm_div #(
  parameter int NW = 21,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] div_r;
  logic [DW:0]   trial;
  logic          fits;

  // one restoring step: shift in next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= DW'(trial - {1'b0, div_r});
      end else begin
        rem_r <= DW'(trial);
      end
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[design/tagged_byte_memory_with_counters_core.sv]
`default_nettype none
// Tagged byte memory: each byte holds a 5-bit instruction and ip, block start
// and allocated flags (bits 5..7), with a 32-entry instruction histogram and
// three flag counters. Take one command when start is high and busy is low;
// busy is also high while the size register is being written. Its single
// result appears for one cycle with out_strobe and cannot be held off, so
// capture it then. The store has one read and one write port, so a read, set
// or clear passes through a byte read and a write-back state, a histogram read
// through a read and an output state, and an instruction write does the byte
// read-modify-write, then a histogram decrement, read and increment through
// the histogram's single write port. A render walks the span one byte a cycle
// and then runs a bit-serial divider. After reset, and after each write of the
// size register, a clearing pass zeroes 2^size_order bytes, one per cycle, with
// busy high; size writes are taken at any time and restart it.
module tagged_byte_memory_with_counters_core #(
  parameter int ADDR_BITS  = tbm_pkg::ADDR_BITS_DEF,
  parameter int INST_KINDS = tbm_pkg::INST_KINDS_DEF,
  parameter int MAX_CELL   = tbm_pkg::MAX_CELL_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              in_opcode,
  input  wire logic [15:0]             in_address,
  input  wire logic [4:0]              in_instruction,
  input  wire logic [1:0]              in_flag_select,
  input  wire logic [16:0]             in_span_len,
  input  wire logic [15:0]             in_pixel_index,
  output logic                         out_strobe,
  output logic [7:0]                   out_value,
  output logic [tbm_pkg::CNT_W-1:0]    out_histogram_count,
  output logic [tbm_pkg::CNT_W-1:0]    out_ip_total,
  output logic [tbm_pkg::CNT_W-1:0]    out_block_start_total,
  output logic [tbm_pkg::CNT_W-1:0]    out_allocated_total,
  output logic                         out_over_capacity,
  output logic                         out_bad_address,
  input  wire logic                    cfg_we,
  input  wire logic [tbm_pkg::ORDER_W-1:0] cfg_wdata
);

  import tbm_pkg::*;

  localparam int HW     = ADDR_BITS + 1;
  localparam int DEPTH  = 1 << ADDR_BITS;
  localparam int HIW    = $clog2(INST_KINDS);
  localparam int CELL_W = $clog2(MAX_CELL) + 1;
  localparam int SUM_W  = $clog2(MAX_CELL) + INST_W;
  localparam int PROD_W = 16 + CELL_W;
  localparam int BASE_W = PROD_W + 1;
  localparam int AW     = BASE_W + 1;
  localparam int RW     = (AW > HW) ? AW : HW;
  localparam int QW     = (HW > 17) ? HW : 17;
  localparam logic [ORDER_W-1:0] ORDER_RST =
    (ADDR_BITS < 16) ? ORDER_W'(ADDR_BITS) : ORDER_W'(16);

  state_t state_r, state_nxt;

  logic [ORDER_W-1:0]   order_r;
  logic [HW-1:0]        size;
  logic [HW-1:0]        clr_r;

  // latched command
  logic [2:0]           op_r;
  logic [15:0]          addr_r;
  logic [INST_W-1:0]    inst_r;
  logic [1:0]           sel_r;
  logic [CELL_W-1:0]    cell_r;
  logic [15:0]          idx_r;
  logic [CELL_W-1:0]    cell_sat;

  // byte store
  logic [BYTE_W-1:0]    mem [DEPTH];
  logic [BYTE_W-1:0]    mem_q;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [BYTE_W-1:0]    mem_wdata;
  logic [ADDR_BITS-1:0] mem_raddr;

  // histogram store with valid bits
  logic [HW-1:0]        hmem [INST_KINDS];
  logic [INST_KINDS-1:0] hvalid_r;
  logic [HW-1:0]        hmem_q;
  logic                 hval_q;
  logic [HIW-1:0]       hidx_q;
  logic [HW-1:0]        hist_q;
  logic                 hist_we;
  logic [HIW-1:0]       hist_widx;
  logic [HW-1:0]        hist_wdata;
  logic [HIW-1:0]       hist_raddr;
  logic [HIW-1:0]       old_r;

  // flag counters
  logic [HW-1:0]        cnt_r [NUM_FLAGS];
  logic                 cnt_inc;
  logic                 cnt_dec;

  // render
  logic [PROD_W-1:0]    prod;
  logic [BASE_W-1:0]    base_r;
  logic [CELL_W-1:0]    j_r;
  logic [AW-1:0]        ren_addr;
  logic                 ren_in;
  logic                 ren_last;
  logic                 pend_v_r;
  logic                 pend_in_r;
  logic [SUM_W-1:0]     sum_r;
  logic [NUM_FLAGS-1:0] flags_r;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;

  // result
  logic                 fin;
  logic [BYTE_W-1:0]    fin_value;
  logic [HW-1:0]        fin_hist;
  logic                 fin_bad;
  logic                 strobe_r;
  logic [BYTE_W-1:0]    value_r;
  logic [HW-1:0]        hist_r;
  logic                 bad_r;

  logic                 accept;
  logic                 in_bad;
  logic                 flag_is_set;
  logic [BYTE_W-1:0]    flag_bit;

  assign size     = HW'(1) << order_r;
  assign accept   = start && (state_r == ST_IDLE) && !cfg_we;
  assign in_bad   = QW'(in_address) >= QW'(size);
  assign prod     = idx_r * cell_r;
  assign ren_addr = AW'(base_r) + AW'(j_r);
  assign ren_in   = RW'(ren_addr) < RW'(size);
  assign ren_last = (CELL_W + 1)'(j_r) + 1'b1 == (CELL_W + 1)'(cell_r);
  assign hist_q   = hval_q ? hmem_q : ((hidx_q == '0) ? size : '0);
  assign flag_bit = BYTE_W'(1) << (FLAG_LSB + 32'(sel_r));
  assign flag_is_set = (mem_q & flag_bit) != '0;

  // clamp span length into 1..MAX_CELL
  always_comb begin
    if (in_span_len == '0) begin
      cell_sat = CELL_W'(1);
    end else if (in_span_len > 17'(MAX_CELL)) begin
      cell_sat = CELL_W'(MAX_CELL);
    end else begin
      cell_sat = CELL_W'(in_span_len);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == size - 1'b1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_READ, OP_WRITE, OP_SET, OP_CLEAR: begin
              if (!in_bad) state_nxt = ST_ACC_RD;
            end
            OP_RENDER: state_nxt = ST_REN_MUL;
            OP_HIST:   state_nxt = ST_HQ_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD: state_nxt = ST_ACC_WB;
      ST_ACC_WB: state_nxt = (op_r == OP_WRITE) ? ST_H_DEC : ST_IDLE;
      ST_H_DEC:  state_nxt = ST_H_RD;
      ST_H_RD:   state_nxt = ST_H_INC;
      ST_H_INC:  state_nxt = ST_IDLE;
      ST_HQ_RD:  state_nxt = ST_HQ_OUT;
      ST_HQ_OUT: state_nxt = ST_IDLE;
      ST_REN_MUL: state_nxt = ST_REN_LOOP;
      ST_REN_LOOP: begin
        if (ren_last) state_nxt = ST_REN_TAIL;
      end
      ST_REN_TAIL: state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) state_nxt = ST_CLEAR;
  end

  // datapath controls and result selection
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = ADDR_BITS'(addr_r);
    mem_wdata  = mem_q;
    mem_raddr  = ADDR_BITS'(addr_r);
    hist_we    = 1'b0;
    hist_widx  = old_r;
    hist_wdata = hist_q;
    hist_raddr = HIW'(inst_r);
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    div_start  = 1'b0;
    fin        = 1'b0;
    fin_value  = '0;
    fin_hist   = '0;
    fin_bad    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_BITS'(clr_r);
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_READ, OP_WRITE, OP_SET, OP_CLEAR: begin
              if (in_bad) begin
                fin     = 1'b1;
                fin_bad = 1'b1;
              end
            end
            OP_RENDER, OP_HIST: fin = 1'b0;
            default: fin = 1'b1;
          endcase
        end
      end
      ST_ACC_WB: begin
        hist_raddr = HIW'(mem_q[INST_W-1:0]);
        case (op_r)
          OP_READ: begin
            fin       = 1'b1;
            fin_value = mem_q;
          end
          OP_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = {mem_q[BYTE_W-1:INST_W], inst_r};
          end
          OP_SET: begin
            fin = 1'b1;
            if (sel_r < 2'(NUM_FLAGS) && !flag_is_set) begin
              mem_we    = 1'b1;
              mem_wdata = mem_q | flag_bit;
              cnt_inc   = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
            if (sel_r < 2'(NUM_FLAGS) && flag_is_set) begin
              mem_we    = 1'b1;
              mem_wdata = mem_q & ~flag_bit;
              cnt_dec   = 1'b1;
            end
          end
        endcase
      end
      ST_H_DEC: begin
        hist_we    = 1'b1;
        hist_widx  = old_r;
        hist_wdata = hist_q - 1'b1;
      end
      ST_H_INC: begin
        hist_we    = 1'b1;
        hist_widx  = HIW'(inst_r);
        hist_wdata = hist_q + 1'b1;
        fin        = 1'b1;
      end
      ST_HQ_OUT: begin
        fin      = 1'b1;
        fin_hist = hist_q;
      end
      ST_REN_LOOP: mem_raddr = ADDR_BITS'(ren_addr);
      ST_DIV_GO:   div_start = 1'b1;
      ST_DIV_WAIT: begin
        if (div_done) begin
          fin       = 1'b1;
          fin_value = BYTE_W'(div_q) | {flags_r, {FLAG_LSB{1'b0}}};
        end
      end
      default: fin = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      order_r  <= ORDER_RST;
      clr_r    <= '0;
      hvalid_r <= '0;
      strobe_r <= 1'b0;
      pend_v_r <= 1'b0;
      for (int k = 0; k < NUM_FLAGS; k++) cnt_r[k] <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= fin;
      pend_v_r <= (state_r == ST_REN_LOOP);
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (hist_we) hvalid_r[hist_widx] <= 1'b1;
      if (cnt_inc) cnt_r[sel_r] <= cnt_r[sel_r] + 1'b1;
      if (cnt_dec) cnt_r[sel_r] <= cnt_r[sel_r] - 1'b1;
      // size write: saturate and restart the clearing pass
      if (cfg_we) begin
        order_r  <= (cfg_wdata > ORDER_W'(ADDR_BITS)) ? ORDER_W'(ADDR_BITS) : cfg_wdata;
        clr_r    <= '0;
        hvalid_r <= '0;
        for (int k = 0; k < NUM_FLAGS; k++) cnt_r[k] <= '0;
      end
    end
  end

  // latch the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      addr_r <= in_address;
      inst_r <= in_instruction;
      sel_r  <= in_flag_select;
      cell_r <= cell_sat;
      idx_r  <= in_pixel_index;
    end
    if (state_r == ST_ACC_WB) old_r <= HIW'(mem_q[INST_W-1:0]);
  end

  // byte store ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // histogram store ports
  always_ff @(posedge clk) begin
    if (hist_we) hmem[hist_widx] <= hist_wdata;
    hmem_q <= hmem[hist_raddr];
    hval_q <= hvalid_r[hist_raddr];
    hidx_q <= hist_raddr;
  end

  // render walk: issue one read a cycle, accumulate the one before
  always_ff @(posedge clk) begin
    if (state_r == ST_REN_MUL) begin
      base_r  <= BASE_W'(addr_r) + BASE_W'(prod);
      j_r     <= '0;
      sum_r   <= '0;
      flags_r <= '0;
    end else begin
      if (state_r == ST_REN_LOOP) begin
        j_r       <= j_r + 1'b1;
        pend_in_r <= ren_in;
      end
      if (pend_v_r && pend_in_r) begin
        sum_r   <= sum_r + SUM_W'(mem_q[INST_W-1:0]);
        flags_r <= flags_r | mem_q[BYTE_W-1:FLAG_LSB];
      end
    end
  end

  tbm_div #(
    .NW(SUM_W),
    .DW(CELL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cell_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // hold the result for its one strobe cycle
  always_ff @(posedge clk) begin
    if (fin) begin
      value_r <= fin_value;
      hist_r  <= fin_hist;
      bad_r   <= fin_bad;
    end
  end

  assign busy                  = (state_r != ST_IDLE) || cfg_we;
  assign out_strobe            = strobe_r;
  assign out_value             = value_r;
  assign out_histogram_count   = CNT_W'(hist_r);
  assign out_ip_total          = CNT_W'(cnt_r[0]);
  assign out_block_start_total = CNT_W'(cnt_r[1]);
  assign out_allocated_total   = CNT_W'(cnt_r[2]);
  assign out_over_capacity     = cnt_r[2] > (size >> 1);
  assign out_bad_address       = bad_r;

endmodule
`default_nettype wire
